// ===== hdl/pfe_pkg.sv =====
// Package for the palette fade engine: sizes, codes, payload and divider types.
package pfe_pkg;

   localparam int ENTRIES   = 16;
   localparam int IDX_W     = 4;
   localparam int COLOR_W   = 12;
   localparam int CHAN_W    = 4;
   localparam int CHANNELS  = COLOR_W / CHAN_W;
   localparam int FRAC_BITS = 10;
   localparam int DIM_W     = FRAC_BITS + 1;
   localparam int STEP_W    = 8;
   localparam int DEN_W     = STEP_W + 4;
   localparam int DIV_W     = FRAC_BITS + DEN_W + 1;
   localparam int DCNT_W    = $clog2(DIV_W);

   localparam logic [DIM_W-1:0] ONE_Q   = DIM_W'(1 << FRAC_BITS);
   localparam logic [DIM_W-1:0] DIM_END = DIM_W'(((1 << FRAC_BITS) * 3 + 5) / 10);

   localparam logic [STEP_W-1:0] STEPS_RESET = STEP_W'(16);

   localparam logic [2:0] REQ_LOAD       = 3'd0;
   localparam logic [2:0] REQ_START_OUT  = 3'd1;
   localparam logic [2:0] REQ_START_IN   = 3'd2;
   localparam logic [2:0] REQ_START_DIM  = 3'd3;
   localparam logic [2:0] REQ_START_SWSH = 3'd4;
   localparam logic [2:0] REQ_TICK       = 3'd5;

   localparam logic CSR_FADE_STEPS   = 1'b0;
   localparam logic CSR_SWOOSH_STEPS = 1'b1;

   typedef struct packed {
      logic [2:0]         req_type;
      logic               cancel_req;
      logic [IDX_W-1:0]   entry_index;
      logic [COLOR_W-1:0] color_word;
   } pfe_req_type;

   typedef struct packed {
      logic [IDX_W-1:0]   out_index;
      logic [COLOR_W-1:0] out_color;
      logic               still_running;
      logic               fade_active;
      logic               last_entry;
   } pfe_rsp_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DEN_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== hdl/pfe_divider.sv =====
// Restoring divider, one quotient bit per cycle, shared by all fade modes.
module pfe_divider
   import pfe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type div_cmd,
   output div_rsp_type div_rsp
);

   logic              busy_ff;
   logic              done_ff;
   logic [DCNT_W-1:0] cnt_ff;
   logic [DEN_W-1:0]  rem_ff;
   logic [DIV_W-1:0]  quo_ff;
   logic [DEN_W-1:0]  den_ff;

   logic [DEN_W:0]    shifted;
   logic              fits;
   logic [DEN_W:0]    diff;

   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign fits    = shifted >= {1'b0, den_ff};
   assign diff    = shifted - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DCNT_W'(DIV_W - 1);
            rem_ff  <= '0;
            quo_ff  <= div_cmd.dividend;
            den_ff  <= div_cmd.divisor;
         end else if (busy_ff) begin
            rem_ff <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            quo_ff <= {quo_ff[DIV_W-2:0], fits};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== hdl/pfe_scaler.sv =====
// Brightness scaler: each RGB444 channel times a Q1.10 level, rounded and clamped.
module pfe_scaler
   import pfe_pkg::*;
(
   input  logic [COLOR_W-1:0] color_in,
   input  logic [DIM_W-1:0]   level,
   output logic [COLOR_W-1:0] color_out
);

   logic [CHAN_W+DIM_W-1:0] prod [CHANNELS];
   logic [CHAN_W+DIM_W:0]   sum  [CHANNELS];
   logic [CHAN_W+1:0]       val  [CHANNELS];

   always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         prod[ch] = (CHAN_W+DIM_W)'(color_in[ch*CHAN_W +: CHAN_W]) *
                    (CHAN_W+DIM_W)'(level);
         sum[ch]  = {1'b0, prod[ch]} + (CHAN_W+DIM_W+1)'(1 << (FRAC_BITS - 1));
         val[ch]  = sum[ch][CHAN_W+DIM_W -: CHAN_W+2];
         color_out[ch*CHAN_W +: CHAN_W] = (val[ch] > (CHAN_W+2)'(15)) ?
                                          CHAN_W'(15) : val[ch][CHAN_W-1:0];
      end
   end

endmodule

// ===== hdl/palette_fade_engine_unit.sv =====
// Top level of the palette fade engine: palette store, sequencer and result register.
//
//  channel | ports                              | transfer when
//  --------+------------------------------------+-------------------------
//  request | req_valid, req_stall, req_data     | req_valid & !req_stall
//  result  | rsp_valid, rsp_stall, rsp_data     | rsp_valid & !rsp_stall
//  config  | csr_wr_en, csr_index, csr_wdata    | csr_wr_en
//
// An item passes an accept state, a decode state and an emit state with sixteen results.
// A tick that keeps a fade running also passes the divide state, using the shared divider.
// The result register accepts a new entry whenever it is empty or being taken;
// a stalled result holds the sequencer in the emit state.
// Synchronous reset: both palettes cleared, no fade running, step registers at 16.
module palette_fade_engine_unit
   import pfe_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pfe_req_type       req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pfe_rsp_type       rsp_data,
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [STEP_W-1:0] csr_wdata
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DECODE = 2'd1;
   localparam logic [1:0] ST_DIV    = 2'd2;
   localparam logic [1:0] ST_EMIT   = 2'd3;

   localparam logic [2:0] MODE_NONE   = 3'd0;
   localparam logic [2:0] MODE_OUT    = 3'd1;
   localparam logic [2:0] MODE_IN     = 3'd2;
   localparam logic [2:0] MODE_DIM    = 3'd3;
   localparam logic [2:0] MODE_SWOOSH = 3'd4;

   localparam logic [2:0] PASS_KEEP  = 3'd0;
   localparam logic [2:0] PASS_COPY  = 3'd1;
   localparam logic [2:0] PASS_BLACK = 3'd2;
   localparam logic [2:0] PASS_DIM   = 3'd3;
   localparam logic [2:0] PASS_LIT   = 3'd4;

   logic [1:0]         state_ff;
   pfe_req_type        item_ff;
   logic [STEP_W-1:0]  fade_steps_ff;
   logic [STEP_W-1:0]  swoosh_steps_ff;
   logic [COLOR_W-1:0] saved_ff [ENTRIES];
   logic [COLOR_W-1:0] shown_ff [ENTRIES];
   logic [2:0]         mode_ff;
   logic [STEP_W-1:0]  count_ff;
   logic [STEP_W-1:0]  total_ff;
   logic [DIM_W-1:0]   dim_ff;
   logic               running_ff;
   logic               run_out_ff;
   logic [2:0]         pass_ff;
   logic               div_lit_ff;
   logic [IDX_W-1:0]   lit_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic               rsp_valid_ff;
   pfe_rsp_type        rsp_data_ff;

   logic [STEP_W-1:0]  count_in;
   logic               tick_end;
   logic [DEN_W-1:0]   den10;
   logic [DEN_W-1:0]   s7;
   logic [DEN_W-1:0]   dim_diff;
   logic               div_go;
   div_cmd_type        div_cmd;
   div_rsp_type        div_rsp;
   logic [COLOR_W-1:0] cur_saved;
   logic [COLOR_W-1:0] cur_shown;
   logic [COLOR_W-1:0] scaled;
   logic [COLOR_W-1:0] new_color;
   logic               out_free;
   logic [2:0]         pass_in;
   logic               rsp_valid_in;

   pfe_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_cmd (div_cmd),
      .div_rsp (div_rsp)
   );

   pfe_scaler u_scaler (
      .color_in  (cur_saved),
      .level     (dim_ff),
      .color_out (scaled)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = ((state_ff == ST_EMIT) && out_free) || (rsp_valid_ff && rsp_stall);

   assign count_in = count_ff + 1'b1;
   assign tick_end = count_in >= total_ff;
   assign den10    = (DEN_W'(total_ff) << 3) + (DEN_W'(total_ff) << 1);
   assign s7       = (DEN_W'(count_in) << 3) - DEN_W'(count_in);
   assign dim_diff = den10 - s7;

   assign div_go = (state_ff == ST_DECODE) && !item_ff.cancel_req &&
                   (item_ff.req_type == REQ_TICK) && running_ff && !tick_end &&
                   (mode_ff == MODE_OUT || mode_ff == MODE_IN ||
                    mode_ff == MODE_DIM || mode_ff == MODE_SWOOSH);

   always_comb begin
      pass_in = PASS_KEEP;
      if (item_ff.cancel_req) begin
         pass_in = PASS_COPY;
      end else if (item_ff.req_type == REQ_START_SWSH) begin
         pass_in = PASS_BLACK;
      end else if ((item_ff.req_type == REQ_TICK) && running_ff && tick_end) begin
         pass_in = PASS_DIM;
      end
   end

   always_comb begin
      div_cmd.start    = div_go;
      div_cmd.dividend = '0;
      div_cmd.divisor  = DEN_W'(total_ff);
      unique case (mode_ff) inside
         MODE_OUT: begin
            div_cmd.dividend = (DIV_W'(total_ff - count_in) << FRAC_BITS) +
                               DIV_W'(total_ff >> 1);
         end
         MODE_IN: begin
            div_cmd.dividend = (DIV_W'(count_in) << FRAC_BITS) + DIV_W'(total_ff >> 1);
         end
         MODE_DIM: begin
            div_cmd.dividend = (DIV_W'(dim_diff) << FRAC_BITS) + DIV_W'(den10 >> 1);
            div_cmd.divisor  = den10;
         end
         MODE_SWOOSH: begin
            div_cmd.dividend = DIV_W'(count_in) << IDX_W;
         end
         default: begin
            div_cmd.dividend = '0;
         end
      endcase
   end

   assign cur_saved = saved_ff[idx_ff];
   assign cur_shown = shown_ff[idx_ff];

   always_comb begin
      case (pass_ff)
         PASS_COPY:  new_color = cur_saved;
         PASS_BLACK: new_color = '0;
         PASS_DIM:   new_color = scaled;
         PASS_LIT:   new_color = (idx_ff <= lit_ff) ? cur_saved : '0;
         default:    new_color = cur_shown;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         fade_steps_ff   <= STEPS_RESET;
         swoosh_steps_ff <= STEPS_RESET;
         for (int i = 0; i < ENTRIES; i++) begin
            saved_ff[i] <= '0;
            shown_ff[i] <= '0;
         end
         mode_ff      <= MODE_NONE;
         count_ff     <= '0;
         total_ff     <= '0;
         dim_ff       <= ONE_Q;
         running_ff   <= 1'b0;
         run_out_ff   <= 1'b0;
         pass_ff      <= PASS_KEEP;
         div_lit_ff   <= 1'b0;
         lit_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_FADE_STEPS:   fade_steps_ff   <= csr_wdata;
               CSR_SWOOSH_STEPS: swoosh_steps_ff <= csr_wdata;
               default:          fade_steps_ff   <= fade_steps_ff;
            endcase
         end

         rsp_valid_ff <= rsp_valid_in;

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  item_ff  <= req_data;
                  state_ff <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               run_out_ff <= div_go;
               div_lit_ff <= (mode_ff == MODE_SWOOSH);
               pass_ff    <= pass_in;
               idx_ff     <= '0;
               state_ff   <= div_go ? ST_DIV : ST_EMIT;
               if (item_ff.cancel_req) begin
                  running_ff <= 1'b0;
                  mode_ff    <= MODE_NONE;
                  dim_ff     <= ONE_Q;
               end else begin
                  unique case (item_ff.req_type) inside
                     REQ_LOAD: begin
                        if ({1'b0, item_ff.entry_index} < (IDX_W+1)'(ENTRIES)) begin
                           saved_ff[item_ff.entry_index] <= item_ff.color_word;
                           shown_ff[item_ff.entry_index] <= item_ff.color_word;
                        end
                     end
                     REQ_START_OUT, REQ_START_IN, REQ_START_DIM, REQ_START_SWSH: begin
                        count_ff   <= '0;
                        running_ff <= 1'b1;
                        unique case (item_ff.req_type) inside
                           REQ_START_OUT: begin
                              mode_ff  <= MODE_OUT;
                              total_ff <= fade_steps_ff;
                              dim_ff   <= ONE_Q;
                           end
                           REQ_START_IN: begin
                              mode_ff  <= MODE_IN;
                              total_ff <= fade_steps_ff;
                              dim_ff   <= '0;
                           end
                           REQ_START_DIM: begin
                              mode_ff  <= MODE_DIM;
                              total_ff <= fade_steps_ff >> 1;
                              dim_ff   <= ONE_Q;
                           end
                           default: begin
                              mode_ff  <= MODE_SWOOSH;
                              total_ff <= swoosh_steps_ff;
                              dim_ff   <= '0;
                           end
                        endcase
                     end
                     REQ_TICK: begin
                        if (running_ff) begin
                           count_ff <= count_in;
                           if (tick_end) begin
                              running_ff <= 1'b0;
                              unique case (mode_ff) inside
                                 MODE_OUT:              dim_ff <= '0;
                                 MODE_IN, MODE_SWOOSH:  dim_ff <= ONE_Q;
                                 MODE_DIM:              dim_ff <= DIM_END;
                                 default:               dim_ff <= dim_ff;
                              endcase
                           end else if (!div_go) begin
                              running_ff <= 1'b0;
                           end
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ST_DIV: begin
               if (div_rsp.done) begin
                  if (div_lit_ff) begin
                     lit_ff  <= div_rsp.quotient[IDX_W-1:0];
                     pass_ff <= PASS_LIT;
                  end else begin
                     dim_ff  <= div_rsp.quotient[DIM_W-1:0];
                     pass_ff <= PASS_DIM;
                  end
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  shown_ff[idx_ff]          <= new_color;
                  rsp_data_ff.out_index     <= idx_ff;
                  rsp_data_ff.out_color     <= new_color;
                  rsp_data_ff.still_running <= run_out_ff;
                  rsp_data_ff.fade_active   <= running_ff;
                  rsp_data_ff.last_entry    <= (idx_ff == IDX_W'(ENTRIES - 1));
                  idx_ff                    <= idx_ff + 1'b1;
                  if (idx_ff == IDX_W'(ENTRIES - 1)) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   a_run_has_mode : assert property (@(posedge clock) disable iff (reset)
      running_ff |-> (mode_ff != MODE_NONE))
      else $error("fade running without a mode");

   a_count_in_range : assert property (@(posedge clock) disable iff (reset)
      running_ff |-> ((count_ff < total_ff) || (count_ff == '0)))
      else $error("step count past total while running");

   a_div_done_in_div : assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV))
      else $error("divider result outside the divide state");

   a_div_start_idle : assert property (@(posedge clock) disable iff (reset)
      div_cmd.start |=> (state_ff == ST_DIV))
      else $error("divider started without waiting for it");

endmodule
